// File: rtl/core/rrtp_pkg.sv
// Package: constants, codes and shared types for the round-robin task picker.
package rrtp_pkg;
  localparam int MaxTasks = 16;
  localparam int TickBits = 32;
  localparam int IdW = 4;
  localparam int PosW = $clog2(MaxTasks);
  localparam int CntW = $clog2(MaxTasks + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_SET = 3'd2;
  localparam logic [2:0] OP_PREEMPT = 3'd3;
  localparam logic [2:0] OP_SCHED = 3'd4;
  localparam logic [2:0] OP_RETURN = 3'd5;

  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_RUNNABLE = 3'd1;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_DEAD = 3'd3;
  localparam logic [2:0] ST_RUNNING = 3'd4;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;
  localparam logic [1:0] STAT_RUNNING = 2'd3;

  // Per-slot task record.
  typedef struct packed {
    logic [2:0]          state;
    logic                preempt;
    logic [TickBits-1:0] wake;
  } slot_t;
endpackage

// File: rtl/core/rrtp_cell.sv
// One ring cell: holds a task id and a valid bit, shifts with its neighbor.
module rrtp_cell import rrtp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  logic [IdW-1:0] id_i,
  input  logic           vld_i,
  output logic [IdW-1:0] id_o,
  output logic           vld_o
);
  logic [IdW-1:0] id_q;
  logic           vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      id_q <= id_i;
    end
  end

  assign id_o  = id_q;
  assign vld_o = vld_q;
endmodule

// File: rtl/core/round_robin_task_picker.sv
// Top level: round-robin task picker over a ring of shift cells.
// One transfer per command. A scan rotates the ring once fully, then the
// APPLY state decodes the command and registers the result on done_o. A
// schedule that picks a task then rotates the valid span in the ROT state
// until the picked task is last. busy is low in the strobe cycle, so the
// next command can be taken at the edge ending it.
// Results cannot be stalled by the receiver. Reset (async, active low) empties
// the ring, clears all slot records and the running task.
module round_robin_task_picker import rrtp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          op_i,
  input  logic [3:0]          task_id_i,
  input  logic [1:0]          new_state_i,
  input  logic [31:0]         wake_tick_i,
  input  logic [31:0]         now_tick_i,
  output logic                done_o,
  output logic [3:0]          chosen_task_o,
  output logic                idle_o,
  output logic [1:0]          status_o
);
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_ROT} state_e;

  state_e         state_q;
  logic [2:0]     op_q;
  logic [IdW-1:0] id_q;
  logic [1:0]     ns_q;
  logic [TickBits-1:0] wk_q, now_q;
  logic [PosW-1:0] step_q;
  logic [CntW-1:0] cnt_q;
  logic            found_q;       // task present in ring
  logic [PosW-1:0] found_pos_q;   // its position from head
  logic            hit_q;         // schedule pick found
  logic [IdW-1:0]  hit_id_q;
  logic [PosW-1:0] hit_pos_q;
  logic            run_vld_q;
  logic [IdW-1:0]  run_id_q;
  slot_t           slot_q [MaxTasks];
  logic            done_q;
  logic [3:0]      chosen_q;
  logic            idle_q;
  logic [1:0]      status_q;

  logic [IdW-1:0] c_id  [MaxTasks];
  logic           c_vld [MaxTasks];
  logic [IdW-1:0] n_id  [MaxTasks];
  logic           n_vld [MaxTasks];
  logic           load;

  // Head is cell 0. Outside a scan, valid entries sit contiguous from the head.
  logic           head_elig;
  slot_t          hs;
  logic           head_is_id;
  always_comb begin
    hs = slot_q[c_id[0]];
    head_is_id = c_vld[0] && (c_id[0] == id_q);
    head_elig = c_vld[0] && (hs.preempt || hs.state == ST_RUNNABLE ||
                (hs.state == ST_SLEEPING && hs.wake != '0 && hs.wake <= now_q));
  end

  logic            scan_done;
  logic            last_step;
  assign last_step = (step_q == PosW'(MaxTasks - 1));

  // Decode of the captured command, used in the APPLY cycle.
  logic            apply;
  logic [1:0]      dec_status;
  logic            dec_idle;
  logic            do_push, do_drop, do_pick, do_ret;
  logic            slot_we;
  logic [IdW-1:0]  slot_wa;
  slot_t           slot_wd;
  slot_t           cur_slot, run_slot;

  assign apply = (state_q == S_APPLY);

  always_comb begin
    cur_slot   = slot_q[id_q];
    run_slot   = slot_q[run_id_q];
    dec_status = STAT_OK;
    dec_idle   = 1'b0;
    do_push    = 1'b0;
    do_drop    = 1'b0;
    do_pick    = 1'b0;
    do_ret     = 1'b0;
    slot_we    = 1'b0;
    slot_wa    = id_q;
    slot_wd    = cur_slot;
    case (op_q)
      OP_ADD: begin
        if (found_q) dec_status = STAT_ABSENT;
        else if (ns_q == ST_DEAD[1:0]) begin
          // dead add: record only, never enters the ring
          slot_we = 1'b1;
          slot_wd = '{state: ST_DEAD, preempt: 1'b0, wake: '0};
        end else if (cnt_q == CntW'(MaxTasks)) dec_status = STAT_FULL;
        else begin
          do_push = 1'b1;
          slot_we = 1'b1;
          slot_wd = '{state: {1'b0, ns_q}, preempt: 1'b0,
                      wake: (ns_q == ST_SLEEPING[1:0]) ? wk_q : '0};
        end
      end
      OP_REMOVE: begin
        if (!found_q) dec_status = STAT_ABSENT;
        else do_drop = 1'b1;
      end
      OP_SET: begin
        if (!found_q) dec_status = STAT_ABSENT;
        else begin
          slot_we = 1'b1;
          slot_wd.state = {1'b0, ns_q};
          if (ns_q == ST_SLEEPING[1:0]) slot_wd.wake = wk_q;
          if (ns_q == ST_DEAD[1:0]) do_drop = 1'b1;
        end
      end
      OP_PREEMPT: begin
        if (!found_q) dec_status = STAT_ABSENT;
        else begin
          slot_we = 1'b1;
          slot_wd.preempt = 1'b1;
        end
      end
      OP_SCHED: begin
        if (run_vld_q) dec_status = STAT_RUNNING;
        else if (!hit_q) dec_idle = 1'b1;
        else begin
          do_pick = 1'b1;
          slot_we = 1'b1;
          slot_wa = hit_id_q;
          slot_wd = '{state: ST_RUNNING, preempt: 1'b0, wake: '0};
        end
      end
      OP_RETURN: begin
        if (!run_vld_q) dec_status = STAT_ABSENT;
        else begin
          do_ret = 1'b1;
          // only a task still marked running goes back to runnable
          if (run_slot.state == ST_RUNNING) begin
            slot_we = 1'b1;
            slot_wa = run_id_q;
            slot_wd = run_slot;
            slot_wd.state = ST_RUNNABLE;
          end
        end
      end
      default: ;
    endcase
  end

  // Ring moves:
  //   SCAN  full left rotation, MaxTasks steps restore the order
  //   ROT   left rotation of the valid span only (head wraps to cell cnt-1)
  //   push  right shift, new id into the head
  //   drop  left shift from the dropped position, tail cell emptied
  always_comb begin
    load = 1'b0;
    for (int i = 0; i < MaxTasks; i++) begin
      n_id[i] = c_id[i];
      n_vld[i] = c_vld[i];
    end
    if (state_q == S_SCAN) begin
      load = 1'b1;
      for (int i = 0; i < MaxTasks - 1; i++) begin
        n_id[i] = c_id[i+1];
        n_vld[i] = c_vld[i+1];
      end
      n_id[MaxTasks-1] = c_id[0];
      n_vld[MaxTasks-1] = c_vld[0];
    end else if (state_q == S_ROT) begin
      load = 1'b1;
      for (int i = 0; i < MaxTasks - 1; i++) begin
        if (CntW'(i + 1) < cnt_q) begin
          n_id[i] = c_id[i+1];
          n_vld[i] = c_vld[i+1];
        end
      end
      for (int i = 0; i < MaxTasks; i++) begin
        if (CntW'(i + 1) == cnt_q) begin
          n_id[i] = c_id[0];
          n_vld[i] = c_vld[0];
        end
      end
    end else if (apply && do_push) begin
      load = 1'b1;
      n_id[0] = id_q;
      n_vld[0] = 1'b1;
      for (int i = 1; i < MaxTasks; i++) begin
        n_id[i] = c_id[i-1];
        n_vld[i] = c_vld[i-1];
      end
    end else if (apply && do_drop) begin
      load = 1'b1;
      for (int i = 0; i < MaxTasks - 1; i++) begin
        if (PosW'(i) >= found_pos_q) begin
          n_id[i] = c_id[i+1];
          n_vld[i] = c_vld[i+1];
        end
      end
      n_vld[MaxTasks-1] = 1'b0;
    end
  end

  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    rrtp_cell u_cell (
      .clk_i, .rst_ni, .load_i(load), .id_i(n_id[g]), .vld_i(n_vld[g]),
      .id_o(c_id[g]), .vld_o(c_vld[g])
    );
  end

  assign scan_done = last_step;
  assign busy = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      id_q        <= '0;
      ns_q        <= '0;
      wk_q        <= '0;
      now_q       <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      run_vld_q   <= 1'b0;
      run_id_q    <= '0;
      done_q      <= 1'b0;
      chosen_q    <= '0;
      idle_q      <= 1'b0;
      status_q    <= STAT_OK;
      found_q     <= 1'b0;
      found_pos_q <= '0;
      hit_q       <= 1'b0;
      hit_id_q    <= '0;
      hit_pos_q   <= '0;
      for (int i = 0; i < MaxTasks; i++) slot_q[i] <= '0;
    end else begin
      // strobe after decode, or after the last pick rotation step
      done_q <= (apply && !do_pick) || (state_q == S_ROT && step_q == hit_pos_q);
      if (apply && slot_we) slot_q[slot_wa] <= slot_wd;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            op_q <= op_i; id_q <= task_id_i; ns_q <= new_state_i;
            wk_q <= wake_tick_i; now_q <= now_tick_i;
            step_q <= '0; found_q <= 1'b0; hit_q <= 1'b0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Full rotation: find task, find first eligible from head.
          if (head_is_id) begin
            found_q <= 1'b1; found_pos_q <= step_q;
          end
          if (head_elig && !hit_q) begin
            hit_q <= 1'b1; hit_id_q <= c_id[0]; hit_pos_q <= step_q;
          end
          step_q <= scan_done ? '0 : step_q + 1'b1;
          if (scan_done) state_q <= S_APPLY;
        end
        S_APPLY: begin
          status_q <= dec_status;
          idle_q   <= dec_idle;
          chosen_q <= do_pick ? hit_id_q : '0;
          state_q  <= do_pick ? S_ROT : S_IDLE;
          if (do_push) cnt_q <= cnt_q + 1'b1;
          else if (do_drop) cnt_q <= cnt_q - 1'b1;
          if (do_pick) begin
            run_vld_q <= 1'b1; run_id_q <= hit_id_q;
          end else if (do_ret) begin
            run_vld_q <= 1'b0; run_id_q <= '0;
          end
        end
        S_ROT: begin
          // span rotations up to step hit_pos leave the picked task last
          if (step_q == hit_pos_q) begin
            step_q <= '0;
            state_q <= S_IDLE;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o        = done_q;
  assign chosen_task_o = chosen_q;
  assign idle_o        = idle_q;
  assign status_o      = status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double result strobe");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && idle_o) |-> (chosen_task_o == '0)) else $error("idle with task");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("strobe while busy");
endmodule

// File: tb/sv/round_robin_task_picker_test.sv
// Testbench: random and directed commands for the round-robin task picker, checked by a predictor.
module round_robin_task_picker_test;
  import rrtp_pkg::*;

  // One expected outcome per command.
  typedef struct {
    logic [3:0] chosen;
    logic       idle;
    logic [1:0] status;
  } outcome_t;

  // Predictor: its own copy of the ring and slot records, plus the store of
  // outcomes still owed by the block.
  class picker_scoreboard;
    logic [3:0]  order[MaxTasks];
    int          count;
    logic [2:0]  slot_st[MaxTasks];
    logic        flag[MaxTasks];
    logic [31:0] wake[MaxTasks];
    logic        run_vld;
    logic [3:0]  run_id;
    outcome_t    pending[$];
    int          errors;
    int          picks, idles, status_seen[4];

    function new();
      count = 0;
      run_vld = 0;
      run_id = '0;
      errors = 0;
      picks = 0;
      idles = 0;
      foreach (slot_st[i]) begin
        order[i] = '0;
        slot_st[i] = ST_NONE;
        flag[i] = 0;
        wake[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pos_of(logic [3:0] id);
      for (int i = 0; i < count; i++)
        if (order[i] == id) return i;
      return -1;
    endfunction

    function void drop(int p);
      for (int i = p; i + 1 < count; i++) order[i] = order[i + 1];
      count--;
    endfunction

    // Work out the outcome of one accepted command.
    function void note_command(logic [2:0] op, logic [3:0] id, logic [1:0] ns,
                               logic [31:0] wk, logic [31:0] now);
      outcome_t   o;
      int         p, hit, k;
      logic [3:0] t;
      logic [3:0] tmp[MaxTasks];
      o.chosen = '0;
      o.idle = 0;
      o.status = STAT_OK;
      p = pos_of(id);
      case (op)
        OP_ADD: begin
          if (p >= 0) begin
            o.status = STAT_ABSENT;
          end else if ({1'b0, ns} == ST_DEAD) begin
            slot_st[id] = ST_DEAD;
            flag[id] = 0;
            wake[id] = '0;
          end else if (count >= MaxTasks) begin
            o.status = STAT_FULL;
          end else begin
            for (int i = count; i > 0; i--) order[i] = order[i - 1];
            order[0] = id;
            count++;
            slot_st[id] = {1'b0, ns};
            flag[id] = 0;
            wake[id] = ({1'b0, ns} == ST_SLEEPING) ? wk : '0;
          end
        end
        OP_REMOVE: begin
          if (p < 0) o.status = STAT_ABSENT;
          else drop(p);
        end
        OP_SET: begin
          if (p < 0) begin
            o.status = STAT_ABSENT;
          end else begin
            slot_st[id] = {1'b0, ns};
            if ({1'b0, ns} == ST_SLEEPING) wake[id] = wk;
            if ({1'b0, ns} == ST_DEAD) drop(p);
          end
        end
        OP_PREEMPT: begin
          if (p < 0) o.status = STAT_ABSENT;
          else flag[id] = 1;
        end
        OP_SCHED: begin
          if (run_vld) begin
            o.status = STAT_RUNNING;
          end else begin
            hit = -1;
            for (int i = 0; i < count; i++) begin
              t = order[i];
              if (flag[t] || slot_st[t] == ST_RUNNABLE ||
                  (slot_st[t] == ST_SLEEPING && wake[t] != 0 && wake[t] <= now)) begin
                hit = i;
                break;
              end
            end
            if (hit < 0) begin
              o.idle = 1;
            end else begin
              // rotate so the picked task ends up last
              t = order[hit];
              k = 0;
              for (int i = hit + 1; i < count; i++) tmp[k++] = order[i];
              for (int i = 0; i <= hit; i++) tmp[k++] = order[i];
              for (int i = 0; i < count; i++) order[i] = tmp[i];
              flag[t] = 0;
              wake[t] = '0;
              slot_st[t] = ST_RUNNING;
              run_vld = 1;
              run_id = t;
              o.chosen = t;
            end
          end
        end
        OP_RETURN: begin
          if (!run_vld) begin
            o.status = STAT_ABSENT;
          end else begin
            if (slot_st[run_id] == ST_RUNNING) slot_st[run_id] = ST_RUNNABLE;
            run_vld = 0;
            run_id = '0;
          end
        end
        default: ;
      endcase
      if (op == OP_SCHED && !o.idle && o.status == STAT_OK) picks++;
      if (o.idle) idles++;
      status_seen[o.status]++;
      pending.push_back(o);
    endfunction

    function void check_outcome(logic [3:0] chosen, logic idle, logic [1:0] status);
      outcome_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result chosen=%0d idle=%0b status=%0d",
                 $time, chosen, idle, status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (chosen !== e.chosen) begin
        $display("%0t: chosen_task expected %0d actual %0d", $time, e.chosen, chosen);
        errors++;
      end
      if (idle !== e.idle) begin
        $display("%0t: idle expected %0b actual %0b", $time, e.idle, idle);
        errors++;
      end
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [2:0]  op_i = '0;
  logic [3:0]  task_id_i = '0;
  logic [1:0]  new_state_i = '0;
  logic [31:0] wake_tick_i = '0;
  logic [31:0] now_tick_i = '0;
  logic        done_o;
  logic [3:0]  chosen_task_o;
  logic        idle_o;
  logic [1:0]  status_o;

  picker_scoreboard board = new();
  int          sent = 0;
  logic [31:0] tick = 32'd100;   // running clock for the task ticks

  round_robin_task_picker dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // Results cannot be held off: take every strobe at the edge ending it.
  always @(posedge clk_i)
    if (rst_ni && done_o) board.check_outcome(chosen_task_o, idle_o, status_o);

  // Hold a command on the ports until the block takes the transfer.
  task automatic issue(logic [2:0] op, logic [3:0] id, logic [1:0] ns,
                       logic [31:0] wk, logic [31:0] now);
    start <= 1;
    op_i <= op;
    task_id_i <= id;
    new_state_i <= ns;
    wake_tick_i <= wk;
    now_tick_i <= now;
    do @(posedge clk_i); while (busy);
    board.note_command(op, id, ns, wk, now);
    sent++;
  endtask

  // Random idle burst on the command side.
  task automatic pause();
    start <= 0;
    repeat ($urandom_range(1, 15)) @(posedge clk_i);
  endtask

  task automatic random_command(bit quiet);
    int          w;
    logic [2:0]  op;
    logic [31:0] wk;
    w = $urandom_range(0, 99);
    // schedule/return heavy mix so tasks actually cycle through running
    if (w < 20) op = OP_ADD;
    else if (w < 28) op = OP_REMOVE;
    else if (w < 43) op = OP_SET;
    else if (w < 53) op = OP_PREEMPT;
    else if (w < 75) op = OP_SCHED;
    else if (w < 96) op = OP_RETURN;
    else op = 3'($urandom_range(6, 7));
    tick += $urandom_range(0, 40);
    case ($urandom_range(0, 3))
      0: wk = $urandom();
      1: wk = '0;
      default: wk = tick + $urandom_range(0, 120) - 40;
    endcase
    issue(op, 4'($urandom()), 2'($urandom()), wk,
          ($urandom_range(0, 9) == 0) ? $urandom() : tick);
    if (!quiet && $urandom_range(0, 3) == 0) pause();
  endtask

  initial begin
    int guard;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty ring cases, every op, field extremes.
    issue(OP_SCHED, 4'd0, 2'd0, '0, '0);              // nothing to run: idle
    issue(OP_RETURN, 4'd0, 2'd0, '0, '0);             // nothing running
    issue(OP_REMOVE, 4'd15, 2'd0, '0, '0);            // absent
    issue(OP_ADD, 4'd3, 2'd3, '1, '0);                // dead add: not inserted
    issue(OP_SET, 4'd3, 2'd1, '0, '0);                // still absent
    issue(OP_ADD, 4'd0, 2'd2, 32'hFFFF_FFFF, '0);     // sleeping, max wake
    issue(OP_ADD, 4'd15, 2'd2, '0, '0);               // sleeping, no timeout
    issue(OP_ADD, 4'd7, 2'd0, 32'h5555_AAAA, '0);     // state none
    issue(OP_ADD, 4'd7, 2'd1, '0, '0);                // duplicate
    issue(OP_SCHED, 4'd0, 2'd0, '0, 32'hFFFF_FFFE);   // wake not yet due: idle
    issue(OP_SCHED, 4'd0, 2'd0, '0, 32'hFFFF_FFFF);   // wake due: picks 0
    issue(OP_SCHED, 4'd0, 2'd0, '0, '1);              // still running
    issue(OP_REMOVE, 4'd0, 2'd0, '0, '0);             // remove the running task
    issue(OP_RETURN, 4'd0, 2'd0, '0, '0);
    issue(OP_PREEMPT, 4'd7, 2'd0, '0, '0);            // preempt overrides state none
    issue(OP_SCHED, 4'd0, 2'd0, '0, '0);
    issue(OP_SET, 4'd7, 2'd3, '0, '0);                // dead while running
    issue(OP_RETURN, 4'd0, 2'd0, '0, '0);             // stays dead
    issue(OP_SET, 4'd15, 2'd2, 32'd1, '0);
    issue(OP_SCHED, 4'd0, 2'd0, '0, 32'd1);
    issue(3'd6, 4'd9, 2'd3, '1, '1);                  // unused op codes
    issue(3'd7, 4'd0, 2'd0, '0, '0);
    issue(OP_RETURN, 4'd0, 2'd0, '0, '0);
    // Fill the ring; an add then only finds duplicates.
    for (int i = 0; i < MaxTasks; i++) issue(OP_ADD, 4'(i), 2'd1, '0, '0);
    issue(OP_ADD, 4'd5, 2'd1, '0, '0);

    // Random part; the last stretch runs back to back.
    for (int i = 0; i < 1500; i++) random_command(0);
    for (int i = 0; i < 100; i++) random_command(1);
    start <= 0;

    guard = 0;
    while (board.pending.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (30) @(posedge clk_i);
    if (board.pending.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, board.pending.size());
      board.errors++;
    end

    $display("Covered %0d commands: %0d picks, %0d idle schedules.",
             sent, board.picks, board.idles);
    $display("Status mix ok/full/absent/running: %0d/%0d/%0d/%0d",
             board.status_seen[0], board.status_seen[1],
             board.status_seen[2], board.status_seen[3]);
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Hang guard: well beyond the slowest correct run.
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

// File: round_robin_task_picker.f
rtl/core/rrtp_pkg.sv
rtl/core/rrtp_cell.sv
rtl/core/round_robin_task_picker.sv
tb/sv/round_robin_task_picker_test.sv
